// ----- sv/tbm_pkg.sv -----
// Shared types and codes of the typed bracket matcher.
// Depends on nothing; every other file of the block but tbm_ram uses it.

package tbm_pkg;

    // Token class codes on the input.
    localparam logic [1:0] CLS_OPEN  = 2'd1;
    localparam logic [1:0] CLS_CLOSE = 2'd2;

    // Decoded operation handed from the front to the back.
    typedef enum logic [1:0] {
        OP_OTHER = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2
    } tbm_op_kind_t;

    // Error codes of a result.
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MISMATCH = 3'd1,
        ERR_NO_OPEN  = 3'd2,
        ERR_UNCLOSED = 3'd3,
        ERR_OVERFLOW = 3'd4
    } tbm_err_t;

    // One request after classification, with its token index.
    typedef struct packed {
        tbm_op_kind_t op;
        logic [1:0]   kind;
        logic [15:0]  offset;
        logic [15:0]  index;
        logic         last;
    } tbm_op_t;

    // One stacked opening bracket.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] offset;
        logic [15:0] index;
    } tbm_entry_t;

    // One result.
    typedef struct packed {
        logic        pair_valid;
        logic [15:0] open_index;
        logic [15:0] close_index;
        tbm_err_t    error_code;
        logic [15:0] error_offset;
        logic [15:0] error_index;
        logic        sequence_done;
    } tbm_result_t;

    // Back-end activity, for checking.
    typedef struct packed {
        logic fire;
        logic last;
    } tbm_status_t;

endpackage

// ----- sv/tbm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.

module tbm_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read of the address being
    // written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/tbm_front.sv -----
// Front end: accepts tokens, numbers them and decodes their class.
// Depends on tbm_pkg.

module tbm_front #(
    parameter int INDEX_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [15:0] source_offset
    input  logic [3:0]       s_tuser,   // [1:0] token_class, [3:2] bracket_kind
    input  logic             s_tlast,   // last_token
    input  logic             q_ready,
    output logic             q_push,
    output tbm_pkg::tbm_op_t q_op
);

    logic [INDEX_BITS-1:0]    pos_reg;
    logic [INDEX_BITS-1:0]    pos_next;
    logic [INDEX_BITS+15:0]   pos_ext;
    logic                     accept;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;
    assign q_push   = accept;

    // Token counter; the last token of a sequence restarts it.
    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            pos_next = s_tlast ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // Index fields show the low 16 bits of the counter.
    assign pos_ext = {16'b0, pos_reg};

    // Classify the token; unknown classes count as other tokens.
    always_comb begin
        case (s_tuser[1:0])
            tbm_pkg::CLS_OPEN:  q_op.op = tbm_pkg::OP_PUSH;
            tbm_pkg::CLS_CLOSE: q_op.op = tbm_pkg::OP_POP;
            default:            q_op.op = tbm_pkg::OP_OTHER;
        endcase
        q_op.kind   = s_tuser[3:2];
        q_op.offset = s_tdata;
        q_op.index  = pos_ext[15:0];
        q_op.last   = s_tlast;
    end

endmodule

// ----- sv/tbm_queue.sv -----
// Two-entry queue of decoded requests between front and back.
// Depends on tbm_pkg.

module tbm_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tbm_pkg::tbm_op_t push_op,
    output logic             ready,
    input  logic             pop,
    output logic             valid,
    output tbm_pkg::tbm_op_t head_op
);

    tbm_pkg::tbm_op_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       level_reg;
    logic [1:0]       level_next;

    assign ready   = (level_reg != 2'd2);
    assign valid   = (level_reg != 2'd0);
    assign head_op = slot_reg[rd_ptr_reg];

    // Fill level follows pushes and pops.
    always_comb begin
        level_next = level_reg;
        case ({push, pop})
            2'b10:   level_next = level_reg + 2'd1;
            2'b01:   level_next = level_reg - 2'd1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            level_reg <= level_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Payload slots need no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- sv/tbm_back.sv -----
// Back end: carries out pushes and pops on the bracket stack and
// registers one result per request. Depends on tbm_pkg and tbm_ram.

module tbm_back #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  tbm_pkg::tbm_op_t                 q_op,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output tbm_pkg::tbm_result_t             m_result,
    output logic [$clog2(STACK_DEPTH+1)-1:0] stack_level,
    output tbm_pkg::tbm_status_t             status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = $bits(tbm_pkg::tbm_entry_t);

    // The top entry lives in registers, entries below it in the RAM; the RAM
    // output or a forwarded write holds the entry just under the top.
    logic [CW-1:0]        count_reg, count_next;
    logic                 err_seen_reg, err_seen_next;
    tbm_pkg::tbm_entry_t  top_reg, top_next;
    logic                 fwd_reg, fwd_next;
    logic [EW-1:0]        fwd_data_reg;
    logic                 valid_reg, valid_next;
    tbm_pkg::tbm_result_t res_reg, res_next;

    logic                 fire;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [EW-1:0]        rdata;
    tbm_pkg::tbm_entry_t  second;
    tbm_pkg::tbm_entry_t  new_entry;
    logic                 err_now;

    tbm_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (top_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    // A request is carried out when the output register can take its result.
    assign fire  = q_valid && (!valid_reg || m_tready);
    assign q_pop = fire;

    assign second    = fwd_reg ? tbm_pkg::tbm_entry_t'(fwd_data_reg)
                               : tbm_pkg::tbm_entry_t'(rdata);
    assign waddr     = AW'(count_reg - CW'(1));
    assign raddr     = AW'(count_next - CW'(2));
    assign new_entry = '{kind: q_op.kind, offset: q_op.offset, index: q_op.index};

    // Stack operation and result of the request at the queue head.
    always_comb begin
        count_next    = count_reg;
        err_seen_next = err_seen_reg;
        top_next      = top_reg;
        we            = 1'b0;
        err_now       = 1'b0;
        res_next      = res_reg;
        if (fire) begin
            res_next = '0;
            res_next.sequence_done = q_op.last;
            if (!err_seen_reg) begin
                case (q_op.op)
                    tbm_pkg::OP_PUSH: begin
                        if (count_reg == CW'(STACK_DEPTH)) begin
                            err_now              = 1'b1;
                            res_next.error_code  = tbm_pkg::ERR_OVERFLOW;
                        end else begin
                            we         = (count_reg != '0);
                            top_next   = new_entry;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    tbm_pkg::OP_POP: begin
                        if (count_reg == '0) begin
                            err_now             = 1'b1;
                            res_next.error_code = tbm_pkg::ERR_NO_OPEN;
                        end else if (top_reg.kind != q_op.kind) begin
                            err_now             = 1'b1;
                            res_next.error_code = tbm_pkg::ERR_MISMATCH;
                        end else begin
                            res_next.pair_valid  = 1'b1;
                            res_next.open_index  = top_reg.index;
                            res_next.close_index = q_op.index;
                            top_next             = second;
                            count_next           = count_reg - CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                if (err_now) begin
                    err_seen_next         = 1'b1;
                    res_next.error_offset = q_op.offset;
                    res_next.error_index  = q_op.index;
                end
                // An opener still stacked at the end of a sequence.
                if (q_op.last && !err_now && count_next != '0) begin
                    res_next.error_code   = tbm_pkg::ERR_UNCLOSED;
                    res_next.error_offset = top_next.offset;
                    res_next.error_index  = top_next.index;
                end
            end
            if (q_op.last) begin
                count_next    = '0;
                err_seen_next = 1'b0;
            end
        end
    end

    // Forward a write that lands on the address read in the same cycle.
    assign fwd_next = we && (waddr == raddr);

    // Output register state.
    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            err_seen_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            count_reg    <= count_next;
            err_seen_reg <= err_seen_next;
            fwd_reg      <= fwd_next;
            valid_reg    <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        fwd_data_reg <= top_reg;
        res_reg      <= res_next;
    end

    assign m_tvalid    = valid_reg;
    assign m_result    = res_reg;
    assign stack_level = count_reg;
    assign status      = '{fire: fire, last: q_op.last};

endmodule

// ----- sv/typed_bracket_matcher.sv -----
// Top level of the typed bracket matcher: front end, request queue and
// stack back end. Depends on tbm_pkg, tbm_front, tbm_queue and tbm_back.
//
//  Channel  Ports          Carries
//  input    s_t*           tuser: class, kind; tdata: offset; tlast: last token
//  result   m_t*           tuser: pair flag; tdata: indexes, error; tlast: done
//
// One token is accepted per cycle while the queue has room, and one result
// follows per token. With no stall a token's request is registered in the
// queue and is then carried out into the output register, which presents
// its result.
// The stack's top entry sits in registers and the entry below it is read
// ahead from a RAM, so pushes and pops can follow back to back.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result holds the back end; the two-entry queue lets the front
// keep taking tokens until it fills.

module typed_bracket_matcher #(
    parameter int STACK_DEPTH = 64,
    parameter int INDEX_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] source_offset
    input  logic [3:0]  s_tuser,   // [1:0] token_class, [3:2] bracket_kind
    input  logic        s_tlast,   // last_token
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [15:0] open_index, [31:16] close_index,
                                   // [34:32] error_code, [50:35] error_offset,
                                   // [66:51] error_index, [71:67] zero
    output logic        m_tuser,   // pair_valid
    output logic        m_tlast    // sequence_done
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic                 q_ready;
    logic                 q_push;
    tbm_pkg::tbm_op_t     q_in_op;
    logic                 q_valid;
    logic                 q_pop;
    tbm_pkg::tbm_op_t     q_head_op;
    tbm_pkg::tbm_result_t result;
    logic [CW-1:0]        stack_level;
    tbm_pkg::tbm_status_t status;

    tbm_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_op     (q_in_op)
    );

    tbm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (q_in_op),
        .ready   (q_ready),
        .pop     (q_pop),
        .valid   (q_valid),
        .head_op (q_head_op)
    );

    tbm_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_op        (q_head_op),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_result    (result),
        .stack_level (stack_level),
        .status      (status)
    );

    // Pack the result onto the stream.
    assign m_tdata = {5'b0, result.error_index, result.error_offset,
                      result.error_code, result.close_index, result.open_index};
    assign m_tuser = result.pair_valid;
    assign m_tlast = result.sequence_done;

    // The stack never holds more than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stack_level <= CW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    // The end of a sequence empties the stack.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.fire && status.last |=> stack_level == '0)
        else $error("stack not empty after last token");

    // A matched pair before the last token never carries an error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && !m_tlast |-> result.error_code == tbm_pkg::ERR_NONE)
        else $error("pair result with error code");

endmodule
